[hw/rtl/qse_pkg.sv]
// Package of shared constants for the quicksort engine.
`default_nettype none
package qse_pkg;
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int DATA_WIDTH_DEF   = 32;
endpackage
`default_nettype wire

[hw/rtl/qse_in_if.sv]
// Input request channel of the quicksort engine: one element per request.
`default_nettype none
interface qse_in_if #(
  parameter int DATA_WIDTH = qse_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value;
  logic                  is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface
`default_nettype wire

[hw/rtl/qse_out_if.sv]
// Output request channel of the quicksort engine: one sorted element per request.
`default_nettype none
interface qse_out_if #(
  parameter int DATA_WIDTH = qse_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] sorted_value;
  logic                  last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/quicksort_engine_unit.sv]
// Quicksort engine top level: load, in-place Lomuto sort, ordered readout.
//
// The engine takes signed elements one per cycle into an element memory of
// MAX_ELEMENTS entries; elements beyond that depth are dropped. The
// request flagged is_last closes the set and starts the sort: the engine is
// not ready until the whole set has been sent out. Each pending range is
// popped from a range stack (S_POP, S_RANGE) and its last element fetched as
// the pivot (S_PIVOT); each scanned element is read and compared (S_SCAN_RD,
// S_SCAN_CMP), each element moved forward past a larger one is swapped
// (S_SWAP_B, S_SWAP_C), and each finished partition pushes its sub-ranges
// (S_PUSH_L, S_PUSH_R). Sorting speed is set by the one read and one write per
// cycle of the element memory. Readout reads each element (S_EMIT_RD),
// registers it (S_EMIT_LD) and holds it valid until the sink takes it
// (S_EMIT_HOLD); the last element carries last_out and the engine then accepts a new set.
`default_nettype none
module quicksort_engine_unit #(
  parameter int MAX_ELEMENTS = qse_pkg::MAX_ELEMENTS_DEF,
  parameter int DATA_WIDTH   = qse_pkg::DATA_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  qse_in_if.sink       in_ch,
  qse_out_if.source    out_ch
);
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int EXT_W = IDX_W + 2;

  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_RANGE, S_PIVOT, S_SCAN_RD, S_SCAN_CMP, S_SWAP_B, S_SWAP_C,
    S_PUSH_L, S_PUSH_R, S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      sp;
  logic [IDX_W-1:0]      lo;
  logic [IDX_W-1:0]      hi;
  logic [CNT_W-1:0]      scan;
  logic [CNT_W-1:0]      place;
  logic [IDX_W-1:0]      k;
  logic [DATA_WIDTH-1:0] pivot_value;
  logic [DATA_WIDTH-1:0] sval;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_value;
  logic                  out_last;

  logic [DATA_WIDTH-1:0] element_store [MAX_ELEMENTS];
  range_t                range_stack [MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] rdata;
  range_t                st_rdata;

  logic                  in_take;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      sp_m1;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [IDX_W-1:0]      mem_ra;
  logic                  st_we;
  range_t                st_wd;
  logic                  scan_at_hi;
  logic                  above;
  logic                  push_l_ok;
  logic                  push_r_ok;
  logic                  room;

  assign in_ch.ready         = (state == S_LOAD);
  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_value;
  assign out_ch.last_out     = out_last;

  assign in_take    = in_ch.valid && (state == S_LOAD);
  assign room       = (count < CNT_W'(MAX_ELEMENTS));
  assign count_next = room ? count + 1'b1 : count;
  assign sp_m1      = sp - 1'b1;
  assign scan_at_hi = (scan[IDX_W-1:0] == hi);
  assign above      = ($signed(rdata) > $signed(pivot_value));
  assign push_l_ok  = (EXT_W'(place) > EXT_W'(lo) + EXT_W'(2));
  assign push_r_ok  = (EXT_W'(place) < EXT_W'(hi));

  // element memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = scan[IDX_W-1:0];
    mem_wd = rdata;
    mem_ra = k;
    case (state)
      S_LOAD: begin
        mem_we = in_take && room;
        mem_wa = count[IDX_W-1:0];
        mem_wd = in_ch.value;
      end
      S_RANGE:    mem_ra = st_rdata.hi;
      S_SCAN_RD:  mem_ra = scan[IDX_W-1:0];
      S_SCAN_CMP: mem_ra = place[IDX_W-1:0];
      S_SWAP_B: begin
        mem_we = 1'b1;
        mem_wa = scan[IDX_W-1:0];
        mem_wd = rdata;
      end
      S_SWAP_C: begin
        mem_we = 1'b1;
        mem_wa = place[IDX_W-1:0];
        mem_wd = sval;
      end
      default: mem_ra = k;
    endcase
  end

  // range stack port control
  always_comb begin
    st_we = 1'b0;
    st_wd = '{lo: lo, hi: hi};
    case (state)
      S_LOAD: begin
        st_we = in_take && in_ch.is_last;
        st_wd = '{lo: '0, hi: sp_m1[IDX_W-1:0] + count_next[IDX_W-1:0]};
      end
      S_PUSH_L: begin
        st_we = push_l_ok && (sp < CNT_W'(MAX_ELEMENTS));
        st_wd = '{lo: lo, hi: place[IDX_W-1:0] - IDX_W'(2)};
      end
      S_PUSH_R: begin
        st_we = push_r_ok && (sp < CNT_W'(MAX_ELEMENTS));
        st_wd = '{lo: place[IDX_W-1:0], hi: hi};
      end
      default: st_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      element_store[mem_wa] <= mem_wd;
    end
    rdata <= element_store[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      range_stack[sp[IDX_W-1:0]] <= st_wd;
    end
    st_rdata <= range_stack[sp_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_take) begin
            count <= count_next;
            if (in_ch.is_last) begin
              k <= '0;
              if (count_next < CNT_W'(2)) begin
                state <= S_EMIT_RD;
              end else begin
                sp    <= CNT_W'(1);
                state <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            sp    <= sp_m1;
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          lo <= st_rdata.lo;
          hi <= st_rdata.hi;
          if (st_rdata.lo >= st_rdata.hi) begin
            state <= S_POP;
          end else begin
            state <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          pivot_value <= rdata;
          scan        <= CNT_W'(lo);
          place       <= CNT_W'(lo);
          state       <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (!above && (scan != place)) begin
            sval  <= rdata;
            state <= S_SWAP_B;
          end else begin
            if (!above) begin
              place <= place + 1'b1;
            end
            if (scan_at_hi) begin
              state <= S_PUSH_L;
            end else begin
              scan  <= scan + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_SWAP_B: begin
          state <= S_SWAP_C;
        end
        S_SWAP_C: begin
          place <= place + 1'b1;
          if (scan_at_hi) begin
            state <= S_PUSH_L;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_PUSH_L: begin
          if (st_we) begin
            sp <= sp + 1'b1;
          end
          state <= S_PUSH_R;
        end
        S_PUSH_R: begin
          if (st_we) begin
            sp <= sp + 1'b1;
          end
          state <= S_POP;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_value <= rdata;
          out_last  <= (CNT_W'(k) + 1'b1 == count);
          out_valid <= 1'b1;
          state     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_valid)
    else $error("input ready while a sorted element is pending");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_W'(MAX_ELEMENTS))
    else $error("range stack pointer beyond depth");

  a_place_behind_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CMP) |-> (place <= scan))
    else $error("partition place index ahead of scan index");

  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.ready && out_last) |=> (in_ch.ready && count == '0))
    else $error("engine not reopened after final sorted element");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond depth");
endmodule
`default_nettype wire
